>>> rtl/cfglcg_pkg.sv
// Package for the configurable LCG random generator.
// Widths, register reset values, request kinds, register indexes and states.
// No dependencies.
package cfglcg_pkg;

   localparam int unsigned DATA_WIDTH        = 32;
   localparam int unsigned FRAC_OUT_WIDTH    = 23;
   localparam int unsigned SPAN_WIDTH        = 34;
   localparam int unsigned ACC_WIDTH         = 35;
   localparam int unsigned NUM_WIDTH         = 36;
   localparam int unsigned CNT_WIDTH         = 7;
   localparam int unsigned CSR_INDEX_WIDTH   = 2;
   localparam int unsigned REQ_TDATA_WIDTH   = 64;
   localparam int unsigned REQ_TUSER_WIDTH   = 2;
   localparam int unsigned RSP_TDATA_WIDTH   = 88;
   localparam int unsigned FRACTION_BITS_DEF = 23;

   localparam logic [DATA_WIDTH-1:0] MUL_RESET  = 32'd69621;
   localparam logic [DATA_WIDTH-1:0] INC_RESET  = 32'd0;
   localparam logic [DATA_WIDTH-1:0] MOD_RESET  = 32'd2147483647;
   localparam logic [DATA_WIDTH-1:0] SEED_RESET = 32'd1349284;

   localparam logic [CNT_WIDTH-1:0] MUL_LAST = 7'd31;
   localparam logic [CNT_WIDTH-1:0] DIV_LAST = 7'd63;

   typedef enum logic [1:0] {
      REQ_FULL,
      REQ_FAST,
      REQ_FRACTION,
      REQ_RANGED
   } req_kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MULTIPLIER,
      CSR_INCREMENT,
      CSR_MODULUS,
      CSR_SEED
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_RNG,
      ST_DONE
   } state_type;

endpackage

>>> rtl/configurable_lcg_random_generator_top.sv
// Configurable LCG random generator, top level.
// Bit-serial multiply, bit-serial restoring modulo and bit-serial range scaling.
// Depends on cfglcg_pkg.
//
// Usage:
//   csr_* writes registers 0 multiplier, 1 increment, 2 modulus, 3 seed.
//   csr_ready is always high; a seed write loads the generator at once.
//   Write registers only while no request is in flight.
//   req_* takes one request: tuser is the request kind, tdata the range bounds.
//   rsp_* returns one result per request: new value, fraction, ranged value.
// Steps from request accept to rsp_tvalid:
//   full step, fraction, ranged: multiply, then modulo, then ST_FIN and ST_DONE,
//   with the multiplier and divider working one bit per cycle;
//   modulus zero skips the modulo, and so does a fast step;
//   ranged requests add the scaling multiply between ST_FIN and ST_DONE.
//   One request is worked on at a time; req_tready rises again when the
//   result moves into the output register.
// Reset loads the register reset values and the generator with the seed.
// When the receiver stalls, the result holds in the output register and the
//   next request is still accepted and computed; it waits for that register.
module configurable_lcg_random_generator_top
   import cfglcg_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // range_low [31:0], range_high [63:32]
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // req_type [1:0]
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // raw_value [31:0], fraction_bits [54:32], ranged_value [86:55], zero [87]
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam logic [DATA_WIDTH-1:0] FRAC_MASK =
      DATA_WIDTH'((64'd1 << FRACTION_BITS) - 64'd1);
   localparam logic [CNT_WIDTH-1:0] RNG_LAST = CNT_WIDTH'(FRACTION_BITS - 1);

   state_type                    state_ff, state_in;
   logic [CNT_WIDTH-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0]        mult_ff, inc_ff, mod_ff;
   logic [DATA_WIDTH-1:0]        cur_ff, cur_in;
   req_kind_type                 kind_ff, kind_in;
   logic signed [DATA_WIDTH-1:0] lo_bound_ff, lo_bound_in;
   logic signed [DATA_WIDTH-1:0] hi_bound_ff, hi_bound_in;
   logic signed [SPAN_WIDTH-1:0] span_ff, span_in;
   logic [DATA_WIDTH-1:0]        mul_hi_ff, mul_hi_in;
   logic [DATA_WIDTH-1:0]        mul_lo_ff, mul_lo_in;
   logic [DATA_WIDTH-1:0]        rem_ff, rem_in;
   logic signed [ACC_WIDTH-1:0]  rng_hi_ff, rng_hi_in;
   logic [FRACTION_BITS-1:0]     rng_lo_ff, rng_lo_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]        rsp_raw_ff, rsp_raw_in;
   logic [FRAC_OUT_WIDTH-1:0]    rsp_frac_ff, rsp_frac_in;
   logic [DATA_WIDTH-1:0]        rsp_ranged_ff, rsp_ranged_in;

   logic                         req_fire;
   logic                         mod_zero;
   logic [DATA_WIDTH:0]          mul_sum;
   logic [DATA_WIDTH:0]          div_trial;
   logic [DATA_WIDTH:0]          div_diff;
   logic [DATA_WIDTH-1:0]        fast_val;
   logic [DATA_WIDTH-1:0]        new_val;
   logic [DATA_WIDTH-1:0]        frac_full;
   logic signed [ACC_WIDTH-1:0]  rng_add;
   logic signed [ACC_WIDTH-1:0]  rng_sum;
   logic signed [NUM_WIDTH-1:0]  a_ext, b_ext, num, num_lo;
   logic signed [NUM_WIDTH-1:0]  num_clamp;
   logic signed [SPAN_WIDTH-1:0] req_a, req_b;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ranged_ff, rsp_frac_ff, rsp_raw_ff};

   assign mod_zero  = (mod_ff == '0);
   assign mul_sum   = {1'b0, mul_hi_ff} + (mul_lo_ff[0] ? {1'b0, mult_ff} : '0);
   assign div_trial = {rem_ff, mul_hi_ff[DATA_WIDTH-1]};
   assign div_diff  = div_trial - {1'b0, mod_ff};
   assign fast_val  = mul_lo_ff - {{(DATA_WIDTH-1){1'b0}}, (mul_lo_ff <= cur_ff)};
   assign new_val   = (kind_ff == REQ_FAST) ? fast_val :
                      (mod_zero ? mul_lo_ff : rem_ff);
   assign frac_full = cur_ff & FRAC_MASK;

   assign req_a   = SPAN_WIDTH'(signed'(req_tdata[31:0]));
   assign req_b   = SPAN_WIDTH'(signed'(req_tdata[63:32]));
   assign rng_add = rng_lo_ff[0] ? ACC_WIDTH'(span_ff) : '0;
   assign rng_sum = rng_hi_ff + rng_add;

   assign a_ext     = NUM_WIDTH'(lo_bound_ff);
   assign b_ext     = NUM_WIDTH'(hi_bound_ff);
   assign num       = a_ext + NUM_WIDTH'(rng_hi_ff);
   assign num_lo    = (num < a_ext) ? a_ext : num;
   assign num_clamp = (num_lo > b_ext) ? b_ext : num_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= MUL_RESET;
         inc_ff  <= INC_RESET;
         mod_ff  <= MOD_RESET;
         cur_ff  <= SEED_RESET;
      end else begin
         cur_ff <= cur_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_MULTIPLIER: mult_ff <= csr_wdata;
               CSR_INCREMENT:  inc_ff  <= csr_wdata;
               CSR_MODULUS:    mod_ff  <= csr_wdata;
               CSR_SEED:       cur_ff  <= csr_wdata;
               default:        ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      lo_bound_ff   <= lo_bound_in;
      hi_bound_ff   <= hi_bound_in;
      span_ff       <= span_in;
      mul_hi_ff     <= mul_hi_in;
      mul_lo_ff     <= mul_lo_in;
      rem_ff        <= rem_in;
      rng_hi_ff     <= rng_hi_in;
      rng_lo_ff     <= rng_lo_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_frac_ff   <= rsp_frac_in;
      rsp_ranged_ff <= rsp_ranged_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      kind_in       = kind_ff;
      lo_bound_in   = lo_bound_ff;
      hi_bound_in   = hi_bound_ff;
      span_in       = span_ff;
      mul_hi_in     = mul_hi_ff;
      mul_lo_in     = mul_lo_ff;
      rem_in        = rem_ff;
      rng_hi_in     = rng_hi_ff;
      rng_lo_in     = rng_lo_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_frac_in   = rsp_frac_ff;
      rsp_ranged_in = rsp_ranged_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in     = req_kind_type'(req_tuser);
               lo_bound_in = signed'(req_tdata[31:0]);
               hi_bound_in = signed'(req_tdata[63:32]);
               span_in     = req_b - req_a + SPAN_WIDTH'(1);
               // high half preloaded with the increment (zero for a fast step): it shifts down into the sum
               mul_hi_in   = (req_kind_type'(req_tuser) == REQ_FAST) ? '0 : inc_ff;
               mul_lo_in   = cur_ff;
               cnt_in      = '0;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_hi_in = mul_sum[DATA_WIDTH:1];
            mul_lo_in = {mul_sum[0], mul_lo_ff[DATA_WIDTH-1:1]};
            cnt_in    = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == MUL_LAST) begin
               cnt_in = '0;
               rem_in = '0;
               if (kind_ff == REQ_FAST || mod_zero) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in    = div_diff[DATA_WIDTH] ? div_trial[DATA_WIDTH-1:0]
                                             : div_diff[DATA_WIDTH-1:0];
            mul_hi_in = {mul_hi_ff[DATA_WIDTH-2:0], mul_lo_ff[DATA_WIDTH-1]};
            mul_lo_in = {mul_lo_ff[DATA_WIDTH-2:0], 1'b0};
            cnt_in    = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cur_in    = new_val;
            rng_hi_in = '0;
            rng_lo_in = new_val[FRACTION_BITS-1:0];
            cnt_in    = '0;
            state_in  = (kind_ff == REQ_RANGED) ? ST_RNG : ST_DONE;
         end
         ST_RNG: begin
            rng_hi_in = {rng_sum[ACC_WIDTH-1], rng_sum[ACC_WIDTH-1:1]};
            rng_lo_in = {rng_sum[0], rng_lo_ff[FRACTION_BITS-1:1]};
            cnt_in    = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == RNG_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = cur_ff;
               rsp_frac_in   = frac_full[FRAC_OUT_WIDTH-1:0];
               rsp_ranged_in = (kind_ff == REQ_RANGED) ? num_clamp[DATA_WIDTH-1:0] : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
